[sv/cld_pkg.sv]
package cld_pkg;

    // line store depth default
    localparam int LINE_LENGTH_DEF = 32;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 4;
    localparam int LIMIT_W = 15;
    localparam int NUM_W   = 24;
    localparam int SVAL_W  = NUM_W + 1;

    // result codes
    localparam logic [CODE_W-1:0] CODE_NONE     = 4'd0;
    localparam logic [CODE_W-1:0] CODE_SET      = 4'd5;
    localparam logic [CODE_W-1:0] CODE_RANGE    = 4'd10;
    localparam logic [CODE_W-1:0] CODE_DECIMAL  = 4'd11;
    localparam logic [CODE_W-1:0] CODE_NUMBER   = 4'd12;
    localparam logic [CODE_W-1:0] CODE_TOO_LONG = 4'd13;

    // characters
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_POINT = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UZ    = 8'h5A;

    // limit register defaults and magnitude cap
    localparam logic signed [LIMIT_W-1:0] UPPER_RESET = 15'sd1000;
    localparam logic signed [LIMIT_W-1:0] LOWER_RESET = -15'sd200;
    localparam logic [NUM_W-1:0]          MAG_CAP     = 24'd1000000;

    // register indexes
    localparam logic REG_UPPER = 1'b0;
    localparam logic REG_LOWER = 1'b1;

    // keyword table: eight direct commands, then set_tlimit
    localparam int KW_COUNT = 9;
    localparam int KW_SET   = 8;
    localparam logic [3:0] KW_SCAN_LAST = 4'd11;

    function automatic logic [3:0] kw_len(input logic [3:0] k);
        logic [3:0] len;
        begin
            unique case (k)
                4'd0:    len = 4'd11;
                4'd1:    len = 4'd8;
                4'd2:    len = 4'd10;
                4'd3:    len = 4'd10;
                4'd4:    len = 4'd8;
                4'd5:    len = 4'd7;
                4'd6:    len = 4'd9;
                4'd7:    len = 4'd7;
                4'd8:    len = 4'd10;
                default: len = 4'd0;
            endcase
            kw_len = len;
        end
    endfunction

    function automatic logic [CODE_W-1:0] kw_code(input logic [3:0] k);
        logic [CODE_W-1:0] code;
        begin
            unique case (k)
                4'd0:    code = 4'd1;
                4'd1:    code = 4'd2;
                4'd2:    code = 4'd3;
                4'd3:    code = 4'd6;
                4'd4:    code = 4'd7;
                4'd5:    code = 4'd8;
                4'd6:    code = 4'd9;
                4'd7:    code = 4'd4;
                4'd8:    code = CODE_SET;
                default: code = CODE_NONE;
            endcase
            kw_code = code;
        end
    endfunction

    // character i of keyword k, zero past its end
    function automatic logic [BYTE_W-1:0] kw_char(input logic [3:0] k, input logic [3:0] i);
        logic [95:0] txt;
        logic [3:0]  len;
        logic [3:0]  pos;
        begin
            unique case (k)
                4'd0:    txt = 96'({"get_", "voltage"});
                4'd1:    txt = 96'({"get_", "temp"});
                4'd2:    txt = 96'({"get_", "status"});
                4'd3:    txt = 96'({"get_", "tlimit"});
                4'd4:    txt = 96'({"get_", "time"});
                4'd5:    txt = 96'("get_log");
                4'd6:    txt = 96'({"clear_", "log"});
                4'd7:    txt = 96'("get_all");
                4'd8:    txt = 96'("set_tlimit");
                default: txt = '0;
            endcase
            len = kw_len(k);
            pos = 4'(len - 4'd1 - i);
            if (i < len)
                kw_char = txt[{pos, 3'b000} +: 8];
            else
                kw_char = CH_NUL;
        end
    endfunction

endpackage

[sv/cld_ram.sv]
module cld_ram
    import cld_pkg::*;
#(
    parameter int WIDTH = BYTE_W,
    parameter int DEPTH = LINE_LENGTH_DEF,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/command_line_decoder.sv]
// Command line decoder. Received characters arrive one per beat on the slave
// stream; each is taken while the decoder is idle and stored in a line
// memory, lowered to lower case, with carriage returns dropped and spaces
// ending words. A newline after a non-empty line starts a decode that blocks
// input: the first word is compared against the nine keywords one stored
// character at a time, each read through the single registered read port
// of the line memory, and for set_tlimit the argument after the last space
// is parsed one character at a time through one shared times-ten-plus-digit
// adder, followed by scaling, sign and range check. A decode keeps the input
// stalled until its result is taken into the output register, which also
// waits while the previous result still waits for the receiver; a syntax
// error ends a set_tlimit decode early. Every decoded line, and every
// overlong line at its newline, gives one result beat: a 4-bit command code
// and the threshold in tenths when the code is "set limit". The limits are
// written through the APB port at 0x0 (upper) and 0x4 (lower).
module command_line_decoder
    import cld_pkg::*;
#(
    parameter int LINE_LENGTH = LINE_LENGTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // rx_byte [7:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // command_code [3:0], limit_value [18:4], zero [23:19]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(LINE_LENGTH);
    localparam int LW = AW + 1;
    localparam logic [AW-1:0] WP_LAST = AW'(LINE_LENGTH - 1);
    localparam logic [LW-1:0] LS_NONE = LW'(LINE_LENGTH);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_M_WAIT = 4'd1;
    localparam logic [3:0] S_M_USE  = 4'd2;
    localparam logic [3:0] S_P_WAIT = 4'd3;
    localparam logic [3:0] S_P_USE  = 4'd4;
    localparam logic [3:0] S_SCALE  = 4'd5;
    localparam logic [3:0] S_NEG    = 4'd6;
    localparam logic [3:0] S_CHECK  = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0]                 state_reg, state_next;
    logic [AW-1:0]              wp_reg, wp_next;
    logic                       ovf_reg, ovf_next;
    logic [LW-1:0]              ls_reg, ls_next;
    logic [AW-1:0]              ptr_reg, ptr_next;
    logic [KW_COUNT-1:0]        alive_reg, alive_next;
    logic                       neg_reg, neg_next;
    logic                       at_start_reg, at_start_next;
    logic                       empty_reg, empty_next;
    logic [1:0]                 dp_reg, dp_next;
    logic [NUM_W-1:0]           num_reg, num_next;
    logic signed [SVAL_W-1:0]   sval_reg, sval_next;
    logic [CODE_W-1:0]          res_code_reg, res_code_next;
    logic signed [LIMIT_W-1:0]  res_val_reg, res_val_next;
    logic                       m_valid_reg, m_valid_next;
    logic [CODE_W-1:0]          m_code_reg, m_code_next;
    logic signed [LIMIT_W-1:0]  m_val_reg, m_val_next;
    logic signed [LIMIT_W-1:0]  upper_reg, lower_reg;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [BYTE_W-1:0]          ram_wdata;
    logic [BYTE_W-1:0]          ram_rdata;

    logic                       in_beat;
    logic [BYTE_W-1:0]          b;
    logic [AW-1:0]              wp_inc;
    logic [NUM_W-1:0]           mac_in;
    logic [3:0]                 mac_digit;
    logic [NUM_W-1:0]           mac_sum;
    logic [NUM_W-1:0]           mac_sat;
    logic [1:0]                 dp_step;
    logic                       is_digit;
    logic                       found;
    logic [CODE_W-1:0]          found_code;

    // line memory
    cld_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LINE_LENGTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // configuration registers
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= UPPER_RESET;
            lower_reg <= LOWER_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == REG_UPPER)
                upper_reg <= pwdata[LIMIT_W-1:0];
            else
                lower_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_LOWER)
            prdata = 32'(lower_reg);
        else
            prdata = 32'(upper_reg);
    end

    // shared unit: times ten plus digit, saturated
    assign mac_in  = num_reg;
    assign mac_sum = {mac_in[NUM_W-4:0], 3'b000} + {mac_in[NUM_W-2:0], 1'b0}
                     + NUM_W'(mac_digit);
    assign mac_sat = (mac_sum > MAG_CAP) ? MAG_CAP : mac_sum;

    assign in_beat  = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign b        = s_tdata;
    assign wp_inc   = (wp_reg == WP_LAST) ? '0 : AW'(wp_reg + 1'b1);
    assign is_digit = (ram_rdata >= CH_0) && (ram_rdata <= CH_9);
    assign dp_step  = (dp_reg != 2'd0) ? 2'(dp_reg + 2'd1) : 2'd0;

    // keyword hit among direct commands
    always_comb
    begin
        found      = 1'b0;
        found_code = CODE_NONE;
        for (int k = 0; k < KW_SET; k++)
        begin
            if (alive_next[k])
            begin
                found      = 1'b1;
                found_code = kw_code(4'(k));
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        ovf_next      = ovf_reg;
        ls_next       = ls_reg;
        ptr_next      = ptr_reg;
        alive_next    = alive_reg;
        neg_next      = neg_reg;
        at_start_next = at_start_reg;
        empty_next    = empty_reg;
        dp_next       = dp_reg;
        num_next      = num_reg;
        sval_next     = sval_reg;
        res_code_next = res_code_reg;
        res_val_next  = res_val_reg;
        ram_we        = 1'b0;
        ram_waddr     = wp_reg;
        ram_wdata     = b;
        mac_digit     = 4'd0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    ram_we = 1'b1;
                    if (ovf_reg)
                    begin
                        if (b == CH_LF)
                        begin
                            ovf_next      = 1'b0;
                            wp_next       = '0;
                            ls_next       = LS_NONE;
                            res_code_next = CODE_TOO_LONG;
                            res_val_next  = '0;
                            state_next    = S_OUT;
                        end
                        else
                        begin
                            wp_next = wp_inc;
                        end
                    end
                    else if (wp_reg == WP_LAST && b != CH_LF)
                    begin
                        ovf_next = 1'b1;
                        wp_next  = '0;
                    end
                    else if (b == CH_SPACE)
                    begin
                        ram_wdata = CH_NUL;
                        ls_next   = LW'(wp_reg);
                        wp_next   = AW'(wp_reg + 1'b1);
                    end
                    else if (b == CH_CR)
                    begin
                        wp_next = wp_reg;
                    end
                    else if (b == CH_LF)
                    begin
                        if (wp_reg != '0)
                        begin
                            ram_wdata  = CH_NUL;
                            wp_next    = '0;
                            ptr_next   = '0;
                            alive_next = '1;
                            state_next = S_M_WAIT;
                        end
                    end
                    else
                    begin
                        if (b >= CH_UA && b <= CH_UZ)
                            ram_wdata = b | 8'h20;
                        wp_next = AW'(wp_reg + 1'b1);
                    end
                end
            end

            S_M_WAIT:
            begin
                state_next = S_M_USE;
            end

            // compare one stored character against every keyword
            S_M_USE:
            begin
                for (int k = 0; k < KW_COUNT; k++)
                begin
                    if (ptr_reg[3:0] <= kw_len(4'(k))
                        && ram_rdata != kw_char(4'(k), ptr_reg[3:0]))
                        alive_next[k] = 1'b0;
                end
                if (ptr_reg[3:0] == KW_SCAN_LAST)
                begin
                    if (found)
                    begin
                        res_code_next = found_code;
                        res_val_next  = '0;
                        state_next    = S_OUT;
                    end
                    else if (alive_next[KW_SET] && ls_reg != LS_NONE)
                    begin
                        ptr_next      = AW'(ls_reg[AW-1:0] + 1'b1);
                        neg_next      = 1'b0;
                        at_start_next = 1'b1;
                        empty_next    = 1'b1;
                        dp_next       = 2'd0;
                        num_next      = '0;
                        state_next    = S_P_WAIT;
                    end
                    else
                    begin
                        res_code_next = CODE_NONE;
                        res_val_next  = '0;
                        state_next    = S_OUT;
                    end
                end
                else
                begin
                    ptr_next   = AW'(ptr_reg + 1'b1);
                    state_next = S_M_WAIT;
                end
            end

            S_P_WAIT:
            begin
                state_next = S_P_USE;
            end

            // one argument character
            S_P_USE:
            begin
                at_start_next = 1'b0;
                res_val_next  = '0;
                if (at_start_reg && ram_rdata == CH_MINUS)
                begin
                    neg_next   = 1'b1;
                    ptr_next   = AW'(ptr_reg + 1'b1);
                    state_next = S_P_WAIT;
                end
                else if (ram_rdata == CH_NUL)
                begin
                    if (empty_reg)
                    begin
                        res_code_next = CODE_NUMBER;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SCALE;
                    end
                end
                else
                begin
                    empty_next = 1'b0;
                    ptr_next   = AW'(ptr_reg + 1'b1);
                    state_next = S_P_WAIT;
                    if (ram_rdata == CH_POINT)
                    begin
                        if (dp_reg != 2'd0)
                        begin
                            res_code_next = CODE_NUMBER;
                            state_next    = S_OUT;
                        end
                        else
                        begin
                            dp_next = 2'd1;
                        end
                    end
                    else if (dp_step == 2'd3)
                    begin
                        res_code_next = CODE_DECIMAL;
                        state_next    = S_OUT;
                    end
                    else if (!is_digit)
                    begin
                        res_code_next = CODE_NUMBER;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        mac_digit = 4'(ram_rdata - CH_0);
                        num_next  = mac_sat;
                        dp_next   = dp_step;
                    end
                end
            end

            // whole numbers are scaled to tenths
            S_SCALE:
            begin
                res_val_next = '0;
                if (dp_reg == 2'd1)
                begin
                    res_code_next = CODE_NUMBER;
                    state_next    = S_OUT;
                end
                else
                begin
                    if (dp_reg == 2'd0)
                        num_next = mac_sum;
                    state_next = S_NEG;
                end
            end

            S_NEG:
            begin
                sval_next  = neg_reg ? -$signed({1'b0, num_reg}) : $signed({1'b0, num_reg});
                state_next = S_CHECK;
            end

            // range check on the signed tenths value
            S_CHECK:
            begin
                if (sval_reg < SVAL_W'(lower_reg) || sval_reg > SVAL_W'(upper_reg))
                begin
                    res_code_next = CODE_RANGE;
                    res_val_next  = '0;
                end
                else
                begin
                    res_code_next = CODE_SET;
                    res_val_next  = sval_reg[LIMIT_W-1:0];
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                ls_next = LS_NONE;
                if (!m_valid_reg || m_tready)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_code_next  = m_code_reg;
        m_val_next   = m_val_reg;
        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;
        if (state_reg == S_OUT && (!m_valid_reg || m_tready))
        begin
            m_valid_next = 1'b1;
            m_code_next  = res_code_reg;
            m_val_next   = res_val_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            wp_reg      <= '0;
            ovf_reg     <= 1'b0;
            ls_reg      <= LS_NONE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            ovf_reg     <= ovf_next;
            ls_reg      <= ls_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        alive_reg    <= alive_next;
        neg_reg      <= neg_next;
        at_start_reg <= at_start_next;
        empty_reg    <= empty_next;
        dp_reg       <= dp_next;
        num_reg      <= num_next;
        sval_reg     <= sval_next;
        res_code_reg <= res_code_next;
        res_val_reg  <= res_val_next;
        m_code_reg   <= m_code_next;
        m_val_reg    <= m_val_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b00000, m_val_reg, m_code_reg};

    // write position stays inside the line memory
    assert property (@(posedge clk) disable iff (!rst_n) wp_reg <= WP_LAST)
        else $error("write position beyond line memory");

    // last space lies before the write position in a normal line
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !ovf_reg) |-> (ls_reg == LS_NONE || ls_reg < LW'(wp_reg)))
        else $error("last space not behind write position");

    // a set-limit result carries a value inside the limits
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_code_reg == CODE_SET)
            |-> (m_val_reg >= lower_reg && m_val_reg <= upper_reg))
        else $error("set-limit value outside limits");

    // every other result carries zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_code_reg != CODE_SET) |-> (m_val_reg == '0))
        else $error("nonzero value on non-set result");

endmodule
